FILE: rtl/ugbi_pkg.sv
`timescale 1ns / 1ps
// Package for the uniform-grid bilinear interpolation unit.
// Holds the item structs and the register and action codes; no dependencies.
package ugbi_pkg;

	typedef struct packed {
		logic              action;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
		logic [5:0]         load_col;
		logic [5:0]         load_row;
		logic signed [31:0] load_value;
	} ugbi_in_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic               in_range;
	} ugbi_out_t;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [2:0] REG_X_ORIGIN = 3'd0;
	localparam logic [2:0] REG_X_STEP   = 3'd1;
	localparam logic [2:0] REG_Y_ORIGIN = 3'd2;
	localparam logic [2:0] REG_Y_STEP   = 3'd3;
	localparam logic [2:0] REG_X_POINTS = 3'd4;
	localparam logic [2:0] REG_Y_POINTS = 3'd5;

	localparam logic [30:0] STEP_RESET   = 31'd65536;
	localparam logic [6:0]  POINTS_RESET = 7'd64;

endpackage

FILE: rtl/ugbi_div_lane.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Uses no package; instantiated per axis by the top level.
module ugbi_div_lane #(
	parameter int DW = 37,
	parameter int NQ = 22
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NQ-1:0] quo
);

	// num < den is required; quo = floor(num * 2^NQ / den)
	logic [DW-1:0] rem_p [1:NQ-1];
	logic [NQ-1:0] quo_p [1:NQ];

	assign quo = quo_p[NQ];

	for (genvar k = 0; k < NQ; k++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [NQ-1:0] quo_in;
		logic [DW:0]   dbl;
		logic [DW:0]   diff;
		logic          ge;
		if (k == 0) begin : g_head
			assign rem_in = num;
			assign quo_in = '0;
		end else begin : g_body
			assign rem_in = rem_p[k];
			assign quo_in = quo_p[k];
		end
		always_comb begin
			dbl  = {rem_in, 1'b0};
			diff = dbl - {1'b0, den};
			ge   = (dbl >= {1'b0, den});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				quo_p[k+1] <= {quo_in[NQ-2:0], ge};
			end
		end
		if (k + 1 < NQ) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_p[k+1] <= ge ? diff[DW-1:0] : dbl[DW-1:0];
				end
			end
		end
	end

endmodule

FILE: rtl/uniform_grid_bilinear_interp_unit.sv
`timescale 1ns / 1ps
// Top level of the uniform-grid bilinear interpolation unit.
// Depends on ugbi_pkg and ugbi_div_lane.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------
//  input    | in_valid/in_stall  | in_item (ugbi_in_t)
//  output   | out_valid/out_stall| out_item (ugbi_out_t)
//  config   | APB write/read     | pwdata / prdata
//
// One item enters per cycle while the output is not stalled; the pipeline is made of the
// one-bit-per-stage cell dividers plus memory read, two multiply and two rounding stages.
// Loads write the four-bank grid memory at the same stage where queries read it.
// Reset clears valid bits and sets the configuration registers to their defaults; the grid is undefined until loaded.
// A stalled output beat freezes the whole pipeline.
module uniform_grid_bilinear_interp_unit
	import ugbi_pkg::*;
#(
	parameter int GRID_X_MAX = 64,
	parameter int GRID_Y_MAX = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  ugbi_in_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output ugbi_out_t   out_item
);

	localparam int GMAX = (GRID_X_MAX > GRID_Y_MAX) ? GRID_X_MAX : GRID_Y_MAX;
	localparam int CB   = $clog2(GMAX);
	localparam int DW   = 31 + CB;
	localparam int NQ   = CB + FRAC_BITS;
	localparam int XH   = (GRID_X_MAX + 1) / 2;
	localparam int YH   = (GRID_Y_MAX + 1) / 2;
	localparam int BD   = XH * YH;
	localparam int AW   = (BD > 1) ? $clog2(BD) : 1;
	localparam int PW   = 34 + FRAC_BITS;
	localparam int MW   = 35 + FRAC_BITS;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;
	localparam logic [PW:0] HALF_P = (PW+1)'(1) << (FRAC_BITS - 1);
	localparam logic [MW:0] HALF_M = (MW+1)'(1) << (FRAC_BITS - 1);

	// configuration registers
	logic signed [31:0] x_origin_q, y_origin_q;
	logic [30:0]        x_step_q, y_step_q;
	logic [6:0]         x_points_q, y_points_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q <= '0;
			y_origin_q <= '0;
			x_step_q   <= STEP_RESET;
			y_step_q   <= STEP_RESET;
			x_points_q <= POINTS_RESET;
			y_points_q <= POINTS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_X_ORIGIN: x_origin_q <= pwdata;
				REG_X_STEP:   x_step_q   <= pwdata[30:0];
				REG_Y_ORIGIN: y_origin_q <= pwdata;
				REG_Y_STEP:   y_step_q   <= pwdata[30:0];
				REG_X_POINTS: x_points_q <= pwdata[6:0];
				REG_Y_POINTS: y_points_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_X_ORIGIN: prdata = x_origin_q;
			REG_X_STEP:   prdata = {1'b0, x_step_q};
			REG_Y_ORIGIN: prdata = y_origin_q;
			REG_Y_STEP:   prdata = {1'b0, y_step_q};
			REG_X_POINTS: prdata = {25'd0, x_points_q};
			REG_Y_POINTS: prdata = {25'd0, y_points_q};
			default:      prdata = '0;
		endcase
	end

	// pipeline enable: everything holds while the output beat is stalled
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// entry: offset from origin, reject negative or beyond 2^CB cells
	logic [30:0]        step_x, step_y;
	logic [DW-1:0]      den_x, den_y, num_x, num_y;
	logic signed [32:0] dx, dy;
	logic               okx0, oky0;

	always_comb begin
		step_x = (x_step_q == '0) ? 31'd1 : x_step_q;
		step_y = (y_step_q == '0) ? 31'd1 : y_step_q;
		den_x  = {step_x, {CB{1'b0}}};
		den_y  = {step_y, {CB{1'b0}}};
		dx     = {in_item.query_x[31], in_item.query_x} - {x_origin_q[31], x_origin_q};
		dy     = {in_item.query_y[31], in_item.query_y} - {y_origin_q[31], y_origin_q};
		okx0   = !dx[32] && (DW'(dx[31:0]) < den_x);
		oky0   = !dy[32] && (DW'(dy[31:0]) < den_y);
		num_x  = okx0 ? DW'(dx[31:0]) : '0;
		num_y  = oky0 ? DW'(dy[31:0]) : '0;
	end

	logic [NQ-1:0] quo_x, quo_y;

	ugbi_div_lane #(.DW(DW), .NQ(NQ)) u_div_x (
		.clk(clk), .en(en), .num(num_x), .den(den_x), .quo(quo_x)
	);
	ugbi_div_lane #(.DW(DW), .NQ(NQ)) u_div_y (
		.clk(clk), .en(en), .num(num_y), .den(den_y), .quo(quo_y)
	);

	// side band traveling alongside the dividers
	logic               vld_s [1:NQ];
	logic               act_s [1:NQ];
	logic               okx_s [1:NQ];
	logic               oky_s [1:NQ];
	logic [5:0]         col_s [1:NQ];
	logic [5:0]         row_s [1:NQ];
	logic signed [31:0] val_s [1:NQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NQ; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= NQ; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s[1] <= in_item.action;
			okx_s[1] <= okx0;
			oky_s[1] <= oky0;
			col_s[1] <= in_item.load_col;
			row_s[1] <= in_item.load_row;
			val_s[1] <= in_item.load_value;
			for (int k = 2; k <= NQ; k++) begin
				act_s[k] <= act_s[k-1];
				okx_s[k] <= okx_s[k-1];
				oky_s[k] <= oky_s[k-1];
				col_s[k] <= col_s[k-1];
				row_s[k] <= row_s[k-1];
				val_s[k] <= val_s[k-1];
			end
		end
	end

	// cell locate and range check, memory access
	logic [CB-1:0]        cx, cy;
	logic [FRAC_BITS-1:0] tx, ty;
	int                   pxe, pye;
	logic                 is_query, in_rng, rd_en, wr_en;
	logic [1:0]           wr_bank;
	logic [AW-1:0]        wr_addr;

	always_comb begin
		cx       = quo_x[NQ-1:FRAC_BITS];
		cy       = quo_y[NQ-1:FRAC_BITS];
		tx       = quo_x[FRAC_BITS-1:0];
		ty       = quo_y[FRAC_BITS-1:0];
		pxe      = (int'(x_points_q) > GRID_X_MAX) ? GRID_X_MAX : int'(x_points_q);
		pye      = (int'(y_points_q) > GRID_Y_MAX) ? GRID_Y_MAX : int'(y_points_q);
		is_query = vld_s[NQ] && (act_s[NQ] == ACT_QUERY);
		in_rng   = okx_s[NQ] && oky_s[NQ] && (int'(cx) + 2 <= pxe) && (int'(cy) + 2 <= pye);
		rd_en    = en && is_query && in_rng;
		wr_en    = en && vld_s[NQ] && (act_s[NQ] == ACT_LOAD) &&
		           (int'(col_s[NQ]) < GRID_X_MAX) && (int'(row_s[NQ]) < GRID_Y_MAX);
		wr_bank  = {row_s[NQ][0], col_s[NQ][0]};
		wr_addr  = AW'((int'(row_s[NQ]) >> 1) * XH + (int'(col_s[NQ]) >> 1));
	end

	logic signed [31:0] bank_s1 [0:3];

	// bank index {row parity, col parity}: the four corners always hit different banks
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam int PR = b / 2;
		localparam int PC = b % 2;
		logic signed [31:0] mem [0:BD-1];
		logic [AW-1:0]      rd_addr;
		always_comb begin
			rd_addr = AW'(((int'(cy) + (PR ^ int'(cy[0]))) >> 1) * XH +
			              ((int'(cx) + (PC ^ int'(cx[0]))) >> 1));
		end
		always_ff @(posedge clk) begin
			if (wr_en && (wr_bank == 2'(b))) begin
				mem[wr_addr] <= val_s[NQ];
			end
			if (rd_en) begin
				bank_s1[b] <= mem[rd_addr];
			end
		end
	end

	logic                 vld_s1, inr_s1, cx0_s1, cy0_s1;
	logic [FRAC_BITS-1:0] tx_s1, ty_s1;
	logic                 vld_s2, inr_s2;
	logic [FRAC_BITS-1:0] ty_s2;
	logic signed [PW-1:0] prod_s2 [0:3];
	logic                 vld_s3, inr_s3;
	logic [FRAC_BITS-1:0] ty_s3;
	logic signed [32:0]   r0_s3, r1_s3;
	logic                 vld_s4, inr_s4;
	logic signed [MW-1:0] m0_s4, m1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= is_query;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_valid <= vld_s4;
		end
	end

	// corner (i,j) sits in bank {cy0^i, cx0^j}
	logic [FRAC_BITS:0]   wx, wyv;
	logic signed [31:0]   v00, v01, v10, v11;
	logic signed [PW:0]   sum0, sum1, sh0, sh1;
	logic signed [MW:0]   msum, mres;
	logic [MW-31:0]       top;

	always_comb begin
		wx   = ONE - {1'b0, tx_s1};
		v00  = bank_s1[{cy0_s1, cx0_s1}];
		v01  = bank_s1[{cy0_s1, !cx0_s1}];
		v10  = bank_s1[{!cy0_s1, cx0_s1}];
		v11  = bank_s1[{!cy0_s1, !cx0_s1}];
		sum0 = {prod_s2[0][PW-1], prod_s2[0]} + {prod_s2[1][PW-1], prod_s2[1]} + HALF_P;
		sum1 = {prod_s2[2][PW-1], prod_s2[2]} + {prod_s2[3][PW-1], prod_s2[3]} + HALF_P;
		sh0  = sum0 >>> FRAC_BITS;
		sh1  = sum1 >>> FRAC_BITS;
		wyv  = ONE - {1'b0, ty_s3};
		msum = {m0_s4[MW-1], m0_s4} + {m1_s4[MW-1], m1_s4} + HALF_M;
		mres = msum >>> FRAC_BITS;
		top  = mres[MW:31];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inr_s1 <= in_rng;
			cx0_s1 <= cx[0];
			cy0_s1 <= cy[0];
			tx_s1  <= tx;
			ty_s1  <= ty;

			inr_s2     <= inr_s1;
			ty_s2      <= ty_s1;
			prod_s2[0] <= PW'(v00) * PW'($signed({1'b0, wx}));
			prod_s2[1] <= PW'(v01) * PW'($signed({1'b0, 1'b0, tx_s1}));
			prod_s2[2] <= PW'(v10) * PW'($signed({1'b0, wx}));
			prod_s2[3] <= PW'(v11) * PW'($signed({1'b0, 1'b0, tx_s1}));

			inr_s3 <= inr_s2;
			ty_s3  <= ty_s2;
			r0_s3  <= sh0[32:0];
			r1_s3  <= sh1[32:0];

			inr_s4 <= inr_s3;
			m0_s4  <= MW'(r0_s3) * MW'($signed({1'b0, wyv}));
			m1_s4  <= MW'(r1_s3) * MW'($signed({1'b0, 1'b0, ty_s3}));

			out_item.in_range <= inr_s4;
			if (!inr_s4) begin
				out_item.interp_value <= '0;
			end else if ((&top) || !(|top)) begin
				out_item.interp_value <= mres[31:0];
			end else if (mres[MW]) begin
				out_item.interp_value <= 32'sh8000_0000;
			end else begin
				out_item.interp_value <= 32'sh7FFF_FFFF;
			end
		end
	end

endmodule
